@@ sv/byte_stream_content_filter_unit_macros.svh @@
// Assertion macros for the byte stream content filter unit.
// Included by the top level; no other dependencies.
`ifndef BYTE_STREAM_CONTENT_FILTER_UNIT_MACROS_SVH
`define BYTE_STREAM_CONTENT_FILTER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/bcf_pkg.sv @@
// Package for the byte stream content filter unit.
// Holds widths, mode codes, character constants and the queue entry types.
package bcf_pkg;

   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 32;
   localparam int MODE_W  = 8;
   localparam int QDEPTH  = 4;
   localparam int QAW     = $clog2(QDEPTH);
   localparam int QCW     = $clog2(QDEPTH + 1);

   localparam logic [MODE_W-1:0] MODE_RESET     = 8'd1;
   localparam logic [MODE_W-1:0] MODE_BITCOUNT  = 8'd1;
   localparam logic [MODE_W-1:0] MODE_PRINTABLE = 8'd2;
   localparam logic [MODE_W-1:0] MODE_DNA       = 8'd3;

   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_ONE   = 8'h31;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
   localparam logic [BYTE_W-1:0] PRINT_LO = 8'd32;
   localparam logic [BYTE_W-1:0] PRINT_HI = 8'd126;

   localparam logic RESULT_BYTE  = 1'b0;
   localparam logic RESULT_COUNT = 1'b1;

   typedef struct packed {
      logic                keep;
      logic                fin;
      logic [BYTE_W-1:0]   data;
      logic [COUNT_W-1:0]  count;
   } bcf_entry_type;

   typedef struct packed {
      logic          valid;
      bcf_entry_type entry;
   } bcf_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } bcf_qstat_type;

endpackage

@@ sv/bcf_req_if.sv @@
// Input channel interface: one data byte and its last flag per word.
// Depends on bcf_pkg for the byte width.
interface bcf_req_if;
   logic                        valid;
   logic                        ready;
   logic [bcf_pkg::BYTE_W-1:0]  data_byte;
   logic                        last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ sv/bcf_rsp_if.sv @@
// Result channel interface: a kept byte or a final count per word.
// Depends on bcf_pkg for the field widths.
interface bcf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        result_kind;
   logic [bcf_pkg::BYTE_W-1:0]  kept_byte;
   logic [bcf_pkg::COUNT_W-1:0] final_count;
   logic                        last_result;

   modport source (output valid, output result_kind, output kept_byte,
                   output final_count, output last_result, input ready);
   modport sink (input valid, input result_kind, input kept_byte,
                 input final_count, input last_result, output ready);
endinterface

@@ sv/bcf_csr_if.sv @@
// Configuration write channel interface carrying the filter mode word.
// Depends on bcf_pkg for the mode width.
interface bcf_csr_if;
   logic                        valid;
   logic                        ready;
   logic [bcf_pkg::MODE_W-1:0]  data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ sv/bcf_queue.sv @@
// Short queue between the classifying front end and the result back end.
// Depends on bcf_pkg for the entry type and depth.
module bcf_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  bcf_pkg::bcf_push_type  push_i,
   input  logic                   pop_i,
   output bcf_pkg::bcf_qstat_type stat_o,
   output bcf_pkg::bcf_entry_type head_o
);
   import bcf_pkg::*;

   bcf_entry_type     mem_ff [QDEPTH];
   logic [QAW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]    count_ff, count_in;
   logic              do_push, do_pop;

   assign stat_o.full  = (count_ff == QCW'(QDEPTH));
   assign stat_o.empty = (count_ff == '0);
   assign head_o       = mem_ff[rd_ptr_ff];
   assign do_push      = push_i.valid && !stat_o.full;
   assign do_pop       = pop_i && !stat_o.empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_i.entry;
      end
   end

endmodule

@@ sv/bcf_front.sv @@
// Front end: accepts input words, classifies them under the filter mode
// and keeps the per-command state. Depends on bcf_pkg and bcf_req_if.
module bcf_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [bcf_pkg::MODE_W-1:0]  mode_i,
   bcf_req_if.sink                     req,
   input  bcf_pkg::bcf_qstat_type      qstat_i,
   output bcf_pkg::bcf_push_type       push_o
);
   import bcf_pkg::*;

   function automatic logic [3:0] popcount8(input logic [BYTE_W-1:0] v);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < BYTE_W; i++) begin
         n = n + {3'b000, v[i]};
      end
      return n;
   endfunction

   function automatic logic is_base(input logic [BYTE_W-1:0] v);
      return v == 8'h41 || v == 8'h43 || v == 8'h47 || v == 8'h54 ||
             v == 8'h61 || v == 8'h63 || v == 8'h67 || v == 8'h74;
   endfunction

   logic [COUNT_W-1:0] running_ff, running_in;
   logic               line_start_ff, line_start_in;
   logic               header_ff, header_in;
   logic               line_start_nx, header_nx;
   logic [BYTE_W-1:0]  c;
   logic [3:0]         add;
   logic               keep, skip, accept, mode_ok;
   logic [COUNT_W-1:0] count_sum;

   assign c         = req.data_byte;
   assign req.ready = !qstat_i.full;
   assign accept    = req.valid && req.ready;
   assign mode_ok   = (mode_i == MODE_BITCOUNT) || (mode_i == MODE_PRINTABLE) ||
                      (mode_i == MODE_DNA);

   always_comb begin
      add           = '0;
      keep          = 1'b0;
      skip          = 1'b0;
      line_start_nx = line_start_ff;
      header_nx     = header_ff;
      case (mode_i)
         MODE_BITCOUNT: begin
            if (c == CH_ZERO || c == CH_ONE || c == CH_SPACE || c == CH_LF || c == CH_CR) begin
               add = {3'b000, c == CH_ONE};
            end else begin
               add = popcount8(c);
            end
         end
         MODE_PRINTABLE: begin
            keep = (c >= PRINT_LO) && (c <= PRINT_HI);
         end
         MODE_DNA: begin
            if (c == CH_LF) begin
               line_start_nx = 1'b1;
               header_nx     = 1'b0;
            end else if (c != CH_CR) begin
               if (line_start_ff) begin
                  line_start_nx = 1'b0;
                  if (c == CH_GT) begin
                     header_nx = 1'b1;
                     skip      = 1'b1;
                  end
               end
               if (!skip && !header_nx) begin
                  keep = is_base(c);
               end
            end
         end
         default: begin
         end
      endcase
      count_sum = running_ff + COUNT_W'(add) + COUNT_W'(keep);
   end

   always_comb begin
      running_in    = running_ff;
      line_start_in = line_start_ff;
      header_in     = header_ff;
      if (accept) begin
         if (req.last_byte) begin
            running_in    = '0;
            line_start_in = 1'b1;
            header_in     = 1'b0;
         end else begin
            running_in    = count_sum;
            line_start_in = line_start_nx;
            header_in     = header_nx;
         end
      end
      push_o.valid       = accept && (keep || req.last_byte);
      push_o.entry.keep  = keep;
      push_o.entry.fin   = req.last_byte;
      push_o.entry.data  = c;
      push_o.entry.count = mode_ok ? count_sum : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff    <= '0;
         line_start_ff <= 1'b1;
         header_ff     <= 1'b0;
      end else begin
         running_ff    <= running_in;
         line_start_ff <= line_start_in;
         header_ff     <= header_in;
      end
   end

endmodule

@@ sv/bcf_back.sv @@
// Back end: drains queue entries into the registered result channel, a kept
// byte first and, for a last word, the final count. Depends on bcf_pkg, bcf_rsp_if.
module bcf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  bcf_pkg::bcf_qstat_type qstat_i,
   input  bcf_pkg::bcf_entry_type head_i,
   output logic                   pop_o,
   bcf_rsp_if.source              rsp
);
   import bcf_pkg::*;

   logic               valid_ff, valid_in;
   logic               phase_ff, phase_in;
   logic               kind_ff, kind_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               last_ff, last_in;
   logic               out_free;

   assign out_free        = !valid_ff || rsp.ready;
   assign rsp.valid       = valid_ff;
   assign rsp.result_kind = kind_ff;
   assign rsp.kept_byte   = byte_ff;
   assign rsp.final_count = count_ff;
   assign rsp.last_result = last_ff;

   always_comb begin
      valid_in = valid_ff;
      phase_in = phase_ff;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      count_in = count_ff;
      last_in  = last_ff;
      pop_o    = 1'b0;
      if (out_free) begin
         valid_in = 1'b0;
         if (!qstat_i.empty) begin
            valid_in = 1'b1;
            if (head_i.keep && !phase_ff) begin
               kind_in  = RESULT_BYTE;
               byte_in  = head_i.data;
               count_in = '0;
               last_in  = !head_i.fin;
               phase_in = head_i.fin;
               pop_o    = !head_i.fin;
            end else begin
               kind_in  = RESULT_COUNT;
               byte_in  = '0;
               count_in = head_i.count;
               last_in  = 1'b1;
               phase_in = 1'b0;
               pop_o    = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
      kind_ff  <= kind_in;
      byte_ff  <= byte_in;
      count_ff <= count_in;
      last_ff  <= last_in;
   end

endmodule

@@ sv/byte_stream_content_filter_unit.sv @@
// Byte stream content filter unit: one input word per cycle while the queue
// is not full; results pass through the queue and a registered output, and an
// input word whose kept byte and final count both go out takes two result words.
// The four-entry queue lets input run while results stall. Synchronous reset
// sets the mode to bit count, clears the command state, queue and output.
module byte_stream_content_filter_unit (
   input  logic       clock,
   input  logic       reset,
   bcf_req_if.sink    req_ch,
   bcf_rsp_if.source  rsp_ch,
   bcf_csr_if.sink    csr_ch
);
   import bcf_pkg::*;
   `include "byte_stream_content_filter_unit_macros.svh"

   logic [MODE_W-1:0] mode_ff, mode_in;
   bcf_push_type      push;
   bcf_qstat_type     qstat;
   bcf_entry_type     head;
   logic              pop;

   assign csr_ch.ready = 1'b1;
   assign mode_in      = (csr_ch.valid && csr_ch.ready) ? csr_ch.data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
      end else begin
         mode_ff <= mode_in;
      end
   end

   bcf_front u_front (
      .clock   (clock),
      .reset   (reset),
      .mode_i  (mode_ff),
      .req     (req_ch),
      .qstat_i (qstat),
      .push_o  (push)
   );

   bcf_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push_i (push),
      .pop_i  (pop),
      .stat_o (qstat),
      .head_o (head)
   );

   bcf_back u_back (
      .clock   (clock),
      .reset   (reset),
      .qstat_i (qstat),
      .head_i  (head),
      .pop_o   (pop),
      .rsp     (rsp_ch)
   );

   `BCF_ASSERT_IMP(a_no_overflow, clock, reset, push.valid, !qstat.full, "queue push while full")
   `BCF_ASSERT_NXT(a_drain, clock, reset, !qstat.empty && (!rsp_ch.valid || rsp_ch.ready), rsp_ch.valid, "pending queue word not presented")
   `BCF_ASSERT_IMP(a_count_word, clock, reset, rsp_ch.valid && rsp_ch.result_kind, rsp_ch.last_result && (rsp_ch.kept_byte == '0), "malformed count word")
   `BCF_ASSERT_IMP(a_byte_word, clock, reset, rsp_ch.valid && !rsp_ch.result_kind, rsp_ch.final_count == '0, "kept byte word carries a count")

endmodule
